// ===== hdl/sva_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_pkg
// Shared widths, codes and item types of the small vector arithmetic unit.
// ----------------------------------------------------------------------------
package sva_pkg;

    localparam int ELEM_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int VEC_N     = 4;
    localparam int CROSS_MIN = 3;
    localparam int FUNC_W    = 4;
    localparam int SIZE_W    = 3;
    localparam int STAT_W    = 2;
    localparam int TOL_W     = 31;
    localparam int TOL_RST   = 1;

    localparam int IN_RAW  = FUNC_W + 2 * SIZE_W + (2 * VEC_N + 1) * ELEM_W;
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW = VEC_N * ELEM_W + SIZE_W + ELEM_W + STAT_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef logic [ELEM_W-1:0] t_elem;

    typedef enum logic [FUNC_W-1:0] {
        F_ADD   = 4'd0,
        F_SUB   = 4'd1,
        F_SCALE = 4'd2,
        F_DOT   = 4'd3,
        F_CROSS = 4'd4,
        F_MAGSQ = 4'd5,
        F_MAG   = 4'd6,
        F_NORM  = 4'd7,
        F_EQ    = 4'd8,
        F_CMP   = 4'd9,
        F_NONE  = 4'd15
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_CROSS    = 2'd2,
        ST_ZERO_MAG = 2'd3
    } t_status;

    typedef struct packed {
        t_func             func;
        t_status           status;
        logic [SIZE_W-1:0] rs;
        t_elem [VEC_N-1:0] a;
        t_elem [VEC_N-1:0] b;
        t_elem             k;
    } t_cls;

    typedef struct packed {
        t_func                             func;
        t_status                           status;
        logic [SIZE_W-1:0]                 rs;
        t_elem [VEC_N-1:0]                 a;
        logic [5:0][2*ELEM_W-1:0]          prod;
        t_elem [VEC_N-1:0]                 vec;
        t_elem                             sc;
        logic [2*ELEM_W-1:0]               sqin;
        logic                              ovf;
        logic [ELEM_W+2:0]                 rem;
        logic [ELEM_W:0]                   root;
        logic [VEC_N-1:0][ELEM_W+FRAC_BITS-1:0] num;
        logic [VEC_N-1:0][ELEM_W+1:0]      drem;
        logic [VEC_N-1:0]                  neg;
    } t_item;

endpackage

// ===== hdl/sva_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_front
// Input register: unpacks an item, resolves sizes, checks them, masks unused
// elements.
// ----------------------------------------------------------------------------
module sva_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [sva_pkg::IN_W-1:0] i_data,
    output logic                     o_push,
    input  logic                     i_full,
    output sva_pkg::t_cls            o_cls
);

    logic          r_fv;
    sva_pkg::t_cls r_cls;
    sva_pkg::t_cls n_cls;

    function automatic logic [sva_pkg::SIZE_W-1:0] eff_size(
        input logic [sva_pkg::SIZE_W-1:0] s);
        logic [sva_pkg::SIZE_W-1:0] r;
        r = s;
        if (s == '0 || s > sva_pkg::SIZE_W'(sva_pkg::VEC_N)) begin
            r = sva_pkg::SIZE_W'(sva_pkg::VEC_N);
        end
        return r;
    endfunction

    always_comb begin
        logic [sva_pkg::SIZE_W-1:0] na;
        logic [sva_pkg::SIZE_W-1:0] nb;
        sva_pkg::t_func             fc;
        logic                       same;
        fc   = sva_pkg::t_func'(i_data[sva_pkg::FUNC_W-1:0]);
        na   = eff_size(i_data[sva_pkg::FUNC_W +: sva_pkg::SIZE_W]);
        nb   = eff_size(i_data[sva_pkg::FUNC_W+sva_pkg::SIZE_W +: sva_pkg::SIZE_W]);
        same = (na == nb);
        if (!(fc inside {sva_pkg::F_ADD, sva_pkg::F_SUB, sva_pkg::F_SCALE, sva_pkg::F_DOT,
                         sva_pkg::F_CROSS, sva_pkg::F_MAGSQ, sva_pkg::F_MAG,
                         sva_pkg::F_NORM, sva_pkg::F_EQ, sva_pkg::F_CMP})) begin
            fc = sva_pkg::F_NONE;
        end
        n_cls.status = sva_pkg::ST_OK;
        n_cls.rs     = sva_pkg::SIZE_W'(sva_pkg::VEC_N);
        for (int i = 0; i < sva_pkg::VEC_N; i++) begin
            n_cls.a[i] = (i < int'(na)) ?
                i_data[sva_pkg::FUNC_W+2*sva_pkg::SIZE_W+i*sva_pkg::ELEM_W +: sva_pkg::ELEM_W]
                : '0;
            n_cls.b[i] = (i < int'(nb)) ?
                i_data[sva_pkg::FUNC_W+2*sva_pkg::SIZE_W+(sva_pkg::VEC_N+i)*sva_pkg::ELEM_W
                       +: sva_pkg::ELEM_W] : '0;
        end
        n_cls.k = i_data[sva_pkg::FUNC_W+2*sva_pkg::SIZE_W+2*sva_pkg::VEC_N*sva_pkg::ELEM_W
                         +: sva_pkg::ELEM_W];
        if (fc inside {sva_pkg::F_ADD, sva_pkg::F_SUB, sva_pkg::F_SCALE, sva_pkg::F_NORM}) begin
            n_cls.rs = na;
        end
        if (fc == sva_pkg::F_CROSS) begin
            n_cls.rs = sva_pkg::SIZE_W'(sva_pkg::CROSS_MIN);
        end
        if (!same && (fc inside {sva_pkg::F_ADD, sva_pkg::F_SUB, sva_pkg::F_DOT,
                                 sva_pkg::F_EQ, sva_pkg::F_CMP})) begin
            n_cls.status = sva_pkg::ST_MISMATCH;
            n_cls.rs     = sva_pkg::SIZE_W'(sva_pkg::VEC_N);
            fc           = sva_pkg::F_NONE;
        end
        if (fc == sva_pkg::F_CROSS && (na < sva_pkg::SIZE_W'(sva_pkg::CROSS_MIN) ||
                                       nb < sva_pkg::SIZE_W'(sva_pkg::CROSS_MIN))) begin
            n_cls.status = sva_pkg::ST_CROSS;
            n_cls.rs     = sva_pkg::SIZE_W'(sva_pkg::VEC_N);
            fc           = sva_pkg::F_NONE;
        end
        n_cls.func = fc;
    end

    assign o_ready = !r_fv || !i_full;
    assign o_push  = r_fv && !i_full;
    assign o_cls   = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (o_ready) begin
            r_fv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cls <= n_cls;
        end
    end

endmodule

// ===== hdl/sva_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_fifo
// Short queue of classified items between the front and the arithmetic
// pipeline.
// ----------------------------------------------------------------------------
module sva_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sva_pkg::t_cls i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sva_pkg::t_cls o_data
);

    sva_pkg::t_cls                r_mem [sva_pkg::Q_DEPTH];
    logic [sva_pkg::Q_PTR_W-1:0]  r_wptr;
    logic [sva_pkg::Q_PTR_W-1:0]  r_rptr;
    logic [sva_pkg::Q_CNT_W-1:0]  r_count;

    assign o_full  = (r_count == sva_pkg::Q_CNT_W'(sva_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sva_pkg::Q_CNT_W'(sva_pkg::Q_DEPTH))
        else $error("queue count beyond depth");
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr - r_rptr) == r_count[sva_pkg::Q_PTR_W-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== hdl/sva_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_back
// Arithmetic pipeline: products, sums, bit-serial square root stages and
// restoring divider stages for normalize, all advancing together.
// ----------------------------------------------------------------------------
module sva_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  sva_pkg::t_cls               i_cls,
    input  logic [sva_pkg::TOL_W-1:0]   i_tol,
    output logic                        o_valid,
    input  logic                        i_out_ready,
    output sva_pkg::t_item              o_item
);

    localparam int E      = sva_pkg::ELEM_W;
    localparam int F      = sva_pkg::FRAC_BITS;
    localparam int N      = sva_pkg::VEC_N;
    localparam int SAT_W  = 2 * E + 3;
    localparam int CMP_W  = (E + 1 > sva_pkg::TOL_W) ? E + 1 : sva_pkg::TOL_W;
    localparam int S_SQ0  = 2;
    localparam int S_MAG  = E + 2;
    localparam int S_DV0  = E + 3;
    localparam int NST    = 2 * E + F + 4;

    localparam logic signed [SAT_W-1:0] HI = {{(SAT_W-E+1){1'b0}}, {(E-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] LO = ~HI;
    localparam logic [E+F-1:0] QHI = {{(F+1){1'b0}}, {(E-1){1'b1}}};
    localparam logic [E+F-1:0] QLO = {{F{1'b0}}, 1'b1, {(E-1){1'b0}}};

    sva_pkg::t_item r_pipe [NST];
    sva_pkg::t_item n_pipe [NST];
    logic [NST-1:0] r_vld;
    logic           en;

    function automatic sva_pkg::t_elem sat_e(input logic signed [SAT_W-1:0] v);
        sva_pkg::t_elem r;
        r = v[E-1:0];
        if (v > HI) begin
            r = HI[E-1:0];
        end else if (v < LO) begin
            r = LO[E-1:0];
        end
        return r;
    endfunction

    function automatic sva_pkg::t_item st_prod(input sva_pkg::t_cls c,
                                               input logic [sva_pkg::TOL_W-1:0] tol);
        sva_pkg::t_item            it;
        sva_pkg::t_elem [5:0]      xs;
        sva_pkg::t_elem [5:0]      ys;
        logic signed [E:0]         ae;
        logic signed [E:0]         be;
        logic signed [E:0]         d;
        logic [E:0]                ad;
        logic signed [E+2:0]       acc;
        logic                      eq;
        it        = '0;
        it.func   = c.func;
        it.status = c.status;
        it.rs     = c.rs;
        it.a      = c.a;
        xs        = '0;
        ys        = '0;
        acc       = '0;
        eq        = 1'b1;
        case (c.func)
            sva_pkg::F_DOT: begin
                for (int i = 0; i < N; i++) begin
                    xs[i] = c.a[i];
                    ys[i] = c.b[i];
                end
            end
            sva_pkg::F_MAGSQ, sva_pkg::F_MAG, sva_pkg::F_NORM: begin
                for (int i = 0; i < N; i++) begin
                    xs[i] = c.a[i];
                    ys[i] = c.a[i];
                end
            end
            sva_pkg::F_SCALE: begin
                for (int i = 0; i < N; i++) begin
                    xs[i] = c.a[i];
                    ys[i] = c.k;
                end
            end
            sva_pkg::F_CROSS: begin
                xs = {c.a[1], c.a[0], c.a[0], c.a[2], c.a[2], c.a[1]};
                ys = {c.b[0], c.b[1], c.b[2], c.b[0], c.b[1], c.b[2]};
            end
            default: begin
            end
        endcase
        for (int j = 0; j < 6; j++) begin
            it.prod[j] = $signed(xs[j]) * $signed(ys[j]);
        end
        for (int i = 0; i < N; i++) begin
            ae = {c.a[i][E-1], c.a[i]};
            be = {c.b[i][E-1], c.b[i]};
            d  = ae - be;
            ad = d[E] ? (E+1)'(-d) : d;
            acc = acc + (E+3)'(d);
            if (CMP_W'(ad) > CMP_W'(tol)) begin
                eq = 1'b0;
            end
            if (c.func == sva_pkg::F_ADD) begin
                it.vec[i] = sat_e(SAT_W'(ae + be));
            end else if (c.func == sva_pkg::F_SUB) begin
                it.vec[i] = sat_e(SAT_W'(d));
            end
        end
        if (c.func == sva_pkg::F_EQ) begin
            it.sc = E'(eq);
        end else if (c.func == sva_pkg::F_CMP) begin
            it.sc = (acc > 0) ? E'(1) : ((acc < 0) ? '1 : '0);
        end
        return it;
    endfunction

    function automatic sva_pkg::t_item st_sum(input sva_pkg::t_item p);
        sva_pkg::t_item           it;
        logic signed [SAT_W-1:0]  acc;
        it  = p;
        acc = '0;
        for (int j = 0; j < N; j++) begin
            acc = acc + SAT_W'($signed(p.prod[j]));
        end
        case (p.func)
            sva_pkg::F_DOT, sva_pkg::F_MAGSQ: begin
                it.sc = sat_e(acc >>> F);
            end
            sva_pkg::F_SCALE: begin
                for (int i = 0; i < N; i++) begin
                    it.vec[i] = sat_e(SAT_W'($signed(p.prod[i])) >>> F);
                end
            end
            sva_pkg::F_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    it.vec[i] = sat_e((SAT_W'($signed(p.prod[2*i]))
                                     - SAT_W'($signed(p.prod[2*i+1]))) >>> F);
                end
            end
            default: begin
            end
        endcase
        it.sqin = acc[2*E-1:0];
        it.ovf  = acc[2*E];
        it.rem  = '0;
        it.root = '0;
        return it;
    endfunction

    function automatic sva_pkg::t_item st_sqrt(input sva_pkg::t_item p, input int bi);
        sva_pkg::t_item it;
        logic [E+2:0]   r2;
        logic [E+2:0]   t;
        it = p;
        r2 = {p.rem[E:0], p.sqin[2*bi +: 2]};
        t  = {1'b0, p.root[E-1:0], 2'b01};
        if (r2 >= t) begin
            it.rem  = r2 - t;
            it.root = {p.root[E-1:0], 1'b1};
        end else begin
            it.rem  = r2;
            it.root = {p.root[E-1:0], 1'b0};
        end
        return it;
    endfunction

    function automatic sva_pkg::t_item st_mag(input sva_pkg::t_item p);
        sva_pkg::t_item it;
        logic [E:0]     m;
        sva_pkg::t_elem ma;
        it = p;
        m  = p.ovf ? {1'b1, {E{1'b0}}} : {1'b0, p.root[E-1:0]};
        it.root = m;
        if (p.func == sva_pkg::F_MAG) begin
            it.sc = (m[E:E-1] != 2'b00) ? HI[E-1:0] : m[E-1:0];
        end
        if (p.func == sva_pkg::F_NORM && m == '0) begin
            it.status = sva_pkg::ST_ZERO_MAG;
        end
        for (int i = 0; i < N; i++) begin
            it.neg[i]  = p.a[i][E-1];
            ma         = p.a[i][E-1] ? -p.a[i] : p.a[i];
            it.num[i]  = {ma, {F{1'b0}}};
            it.drem[i] = '0;
        end
        return it;
    endfunction

    function automatic sva_pkg::t_item st_div(input sva_pkg::t_item p);
        sva_pkg::t_item it;
        logic [E+1:0]   r2;
        logic           qb;
        it = p;
        for (int i = 0; i < N; i++) begin
            r2 = {p.drem[i][E:0], p.num[i][E+F-1]};
            qb = (r2 >= {1'b0, p.root});
            it.drem[i] = qb ? r2 - {1'b0, p.root} : r2;
            it.num[i]  = {p.num[i][E+F-2:0], qb};
        end
        return it;
    endfunction

    function automatic sva_pkg::t_item st_fin(input sva_pkg::t_item p);
        sva_pkg::t_item it;
        logic [E+F-1:0] q;
        it = p;
        if (p.func == sva_pkg::F_NORM && p.status == sva_pkg::ST_OK) begin
            for (int i = 0; i < N; i++) begin
                q = p.num[i];
                if (!p.neg[i]) begin
                    it.vec[i] = (q > QHI) ? HI[E-1:0] : q[E-1:0];
                end else begin
                    it.vec[i] = (q > QLO) ? LO[E-1:0] : -q[E-1:0];
                end
            end
        end
        return it;
    endfunction

    assign en      = !r_vld[NST-1] || i_out_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NST-1];
    assign o_item  = r_pipe[NST-1];

    always_comb n_pipe[0] = st_prod(i_cls, i_tol);

    for (genvar s = 1; s < NST; s++) begin : g_stage
        if (s == 1) begin : g_sum
            always_comb n_pipe[s] = st_sum(r_pipe[s-1]);
        end else if (s < S_MAG) begin : g_sqrt
            always_comb n_pipe[s] = st_sqrt(r_pipe[s-1], E - 1 - (s - S_SQ0));
        end else if (s == S_MAG) begin : g_mag
            always_comb n_pipe[s] = st_mag(r_pipe[s-1]);
        end else if (s < NST - 1) begin : g_div
            always_comb n_pipe[s] = st_div(r_pipe[s-1]);
        end else begin : g_fin
            always_comb n_pipe[s] = st_fin(r_pipe[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NST; s++) begin
                r_pipe[s] <= n_pipe[s];
            end
        end
    end

`ifndef SYNTHESIS
    a_zero_mag_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST-1] && r_pipe[NST-1].status == sva_pkg::ST_ZERO_MAG)
        |-> r_pipe[NST-1].func == sva_pkg::F_NORM)
        else $error("zero magnitude status on an operation other than normalize");
    a_vec_scalar_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST-1] && (r_pipe[NST-1].func == sva_pkg::F_ADD ||
                          r_pipe[NST-1].func == sva_pkg::F_SUB ||
                          r_pipe[NST-1].func == sva_pkg::F_SCALE ||
                          r_pipe[NST-1].func == sva_pkg::F_CROSS ||
                          r_pipe[NST-1].func == sva_pkg::F_NORM))
        |-> r_pipe[NST-1].sc == '0)
        else $error("vector operation produced a scalar result");
`endif

endmodule

// ===== hdl/small_vector_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_vector_alu
// Arithmetic unit for vectors of one to four signed Q16.16 elements.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel: operation code, both vector sizes, both
// vectors and a scalar. Each item gives exactly one result on m_axis: four
// result elements, result size, scalar result and status.
// The user must write the match tolerance via i_cfg_we / i_cfg_wdata only
// while the unit is idle (unchecked by the unit); reset sets it to one LSB.
// Throughput is one item per cycle for every operation while m_axis_tready is
// high. With an empty queue an item passes from acceptance to m_axis_tvalid
// through one input register, one queue slot, a product stage, a sum stage,
// 32 square-root stages, a magnitude stage, 48 restoring divider stages and a
// final saturation stage; the divider stages serve normalize.
// While a result waits and m_axis_tready is low the pipeline holds; the
// four-entry queue and the input register keep taking items until they fill,
// then s_axis_tready falls. Reset empties the queue, drops all items in flight.
// ----------------------------------------------------------------------------
module small_vector_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // func, size_a, size_b, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor
    input  logic [sva_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // r_x, r_y, r_z, r_w, result_size, scalar_result, status
    output logic [sva_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [sva_pkg::TOL_W-1:0]     i_cfg_wdata
);

    logic [sva_pkg::TOL_W-1:0] r_tol;
    logic                      push;
    logic                      full;
    logic                      empty;
    logic                      bk_ready;
    sva_pkg::t_cls             f_cls;
    sva_pkg::t_cls             q_cls;
    sva_pkg::t_item            o_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= sva_pkg::TOL_W'(sva_pkg::TOL_RST);
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    sva_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_push  (push),
        .i_full  (full),
        .o_cls   (f_cls)
    );

    sva_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_cls),
        .o_full  (full),
        .i_pop   (bk_ready && !empty),
        .o_empty (empty),
        .o_data  (q_cls)
    );

    sva_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!empty),
        .o_ready     (bk_ready),
        .i_cls       (q_cls),
        .i_tol       (r_tol),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_item      (o_item)
    );

    assign m_axis_tdata = sva_pkg::OUT_W'({o_item.status, o_item.sc, o_item.rs,
                                           o_item.vec[3], o_item.vec[2],
                                           o_item.vec[1], o_item.vec[0]});

endmodule
